### src/vvts_pkg.sv
// Package for the voxel volume sampler: transaction structs, register
// indexes, op codes and default sizing. No dependencies.
package vvts_pkg;

  localparam int DIM_MAX_DEF   = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SIZE_MIN      = 2;
  localparam int DATA_W        = 32;
  localparam int CFG_IDX_W     = 3;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE = 3'd6;

  localparam logic [6:0]  SIZE_RST      = 7'd64;
  localparam logic [31:0] INV_SCALE_RST = 32'd65536;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] voxel_x;
    logic signed [15:0] voxel_y;
    logic signed [15:0] voxel_z;
    logic signed [31:0] write_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
  } rsp_t;

endpackage

### src/vvts_store.sv
// Single-port voxel store with registered read data.
// Depends on vvts_pkg for default depth and word width.
module vvts_store #(
  parameter int DEPTH = vvts_pkg::DIM_MAX_DEF ** 3,
  parameter int WIDTH = vvts_pkg::DATA_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/voxel_volume_trilinear_sampler_core.sv
// Voxel volume with single-voxel access, whole-store fill and trilinear sampling.
// Depends on vvts_pkg and vvts_store.
//
// Usage: drive req_i and raise start while busy is low; the transaction is taken
// at that edge. Exactly one result follows on rsp_o, marked by done_o for one
// cycle; the receiver cannot stall it. The next start may coincide with done_o.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// Sequence per transaction (one shared multiplier, one store port):
//   read/write: index steps ST_IDX0 to ST_IDX3, then the store access, and
//   for a read a wait on the registered data; out-of-range read/write is
//   answered from idle; sample: 3 axis maps (ST_MAP, ST_MAPCHK), the index
//   steps, 8 store reads paired with 4 x-lerps, 3 y/z lerps; a failed sample
//   ends from idle or a map step; clear writes all words, one word per cycle.
// After reset the store is swept to zero, one word per cycle, while busy stays
// high. Config writes are taken. One transaction runs at a time: the next
// start is taken only when busy is low again.
module voxel_volume_trilinear_sampler_core #(
  parameter int DIM_MAX   = vvts_pkg::DIM_MAX_DEF,
  parameter int FRAC_BITS = vvts_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  vvts_pkg::req_t                     req_i,
  output logic                               done_o,
  output vvts_pkg::rsp_t                     rsp_o,
  input  logic                               cfg_we_i,
  input  logic [vvts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [vvts_pkg::DATA_W-1:0]        cfg_data_i
);
  import vvts_pkg::*;

  localparam int DEPTH = DIM_MAX ** 3;
  localparam int ADW   = $clog2(DEPTH);
  localparam int AW    = (DIM_MAX > 2) ? $clog2(DIM_MAX) : 1;
  localparam int SW    = $clog2(DIM_MAX + 1);
  localparam int SXW   = $clog2(DIM_MAX * DIM_MAX + 1);
  localparam int IPW   = 66 - 2 * FRAC_BITS;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_MAP, ST_MAPCHK, ST_IDX0, ST_IDX1, ST_IDX2, ST_IDX3,
    ST_RW, ST_RDWAIT, ST_XA, ST_XB, ST_XM, ST_XR, ST_LM, ST_LR
  } state_e;

  // configuration
  logic [6:0]  size_x_q, size_y_q, size_z_q;
  logic [31:0] org_x_q, org_y_q, org_z_q, inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RST;
      size_y_q <= SIZE_RST;
      size_z_q <= SIZE_RST;
      org_x_q  <= '0;
      org_y_q  <= '0;
      org_z_q  <= '0;
      inv_q    <= INV_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE_X:    size_x_q <= cfg_data_i[6:0];
        CFG_SIZE_Y:    size_y_q <= cfg_data_i[6:0];
        CFG_SIZE_Z:    size_z_q <= cfg_data_i[6:0];
        CFG_ORIGIN_X:  org_x_q  <= cfg_data_i;
        CFG_ORIGIN_Y:  org_y_q  <= cfg_data_i;
        CFG_ORIGIN_Z:  org_z_q  <= cfg_data_i;
        CFG_INV_SCALE: inv_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [SW-1:0] eff_size(logic [6:0] raw);
    if (int'(raw) < SIZE_MIN) return SW'(SIZE_MIN);
    if (int'(raw) > DIM_MAX) return SW'(DIM_MAX);
    return SW'(raw);
  endfunction

  function automatic logic in_axis(logic signed [15:0] v, logic [SW-1:0] s);
    return !v[15] && ({1'b0, v[14:0]} < 16'(s));
  endfunction

  logic [SW-1:0] sx, sy, sz;
  assign sx = eff_size(size_x_q);
  assign sy = eff_size(size_y_q);
  assign sz = eff_size(size_z_q);

  // state and datapath registers
  state_e               state_q;
  req_t                 item_q;
  logic [ADW-1:0]       clr_cnt_q;
  logic [31:0]          clr_val_q;
  logic                 clr_rsp_q;
  logic [1:0]           ax_q;
  logic [1:0]           pair_q;
  logic [1:0]           lstep_q;
  logic [AW-1:0]        cx_q, cy_q, cz_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q, fz_q;
  logic [SXW-1:0]       sxy_q;
  logic [ADW-1:0]       base_q;
  logic signed [31:0]   lerp_a_q;
  logic signed [31:0]   c_q [4];
  logic signed [31:0]   y0_q, y1_q;
  logic signed [65:0]   prod_q;
  logic                 done_q;
  rsp_t                 rsp_q;

  // store port
  logic           mem_we;
  logic [ADW-1:0] mem_addr;
  logic [31:0]    mem_wdata;
  logic [31:0]    mem_rdata;

  vvts_store #(.DEPTH(DEPTH), .WIDTH(DATA_W)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // per-axis selection for the map steps
  logic [31:0]        pt_sel, org_sel;
  logic [SW-1:0]      size_sel;
  logic signed [32:0] delta;
  logic [IPW-1:0]     ip;
  logic [FRAC_BITS-1:0] fr;
  logic               ip_out, ip_last;

  always_comb begin
    case (ax_q)
      2'd0: begin pt_sel = item_q.point_x; org_sel = org_x_q; size_sel = sx; end
      2'd1: begin pt_sel = item_q.point_y; org_sel = org_y_q; size_sel = sy; end
      default: begin pt_sel = item_q.point_z; org_sel = org_z_q; size_sel = sz; end
    endcase
  end

  assign delta   = $signed({pt_sel[31], pt_sel}) - $signed({org_sel[31], org_sel});
  assign ip      = prod_q[65:2*FRAC_BITS];
  assign fr      = prod_q[2*FRAC_BITS-1:FRAC_BITS];
  assign ip_out  = ip >= IPW'(size_sel);
  assign ip_last = ip == (IPW'(size_sel) - IPW'(1));

  // lerp operand selection for the y and z steps
  logic signed [31:0]   la, lb;
  logic [FRAC_BITS-1:0] lf;
  logic signed [31:0]   lerp_res;

  always_comb begin
    case (lstep_q)
      2'd0:    begin la = c_q[3]; lb = c_q[2]; lf = fy_q; end
      2'd1:    begin la = c_q[1]; lb = c_q[0]; lf = fy_q; end
      default: begin la = y0_q;   lb = y1_q;   lf = fz_q; end
    endcase
  end

  assign lerp_res = lerp_a_q + $signed(prod_q[FRAC_BITS+31:FRAC_BITS]);

  // corner address: base plus x, y and z steps
  logic           cbx;
  logic [ADW-1:0] corner_addr;
  assign cbx = (state_q == ST_XB);
  assign corner_addr = base_q + ADW'(cbx)
                     + (pair_q[0] ? ADW'(sx) : '0)
                     + (pair_q[1] ? ADW'(sxy_q) : '0);

  // shared multiplier operands
  logic signed [32:0] ma_d, mb_d;
  logic signed [31:0] rd_s;
  assign rd_s = $signed(mem_rdata);

  always_comb begin
    ma_d = '0;
    mb_d = '0;
    case (state_q)
      ST_MAP:  begin ma_d = delta; mb_d = $signed({1'b0, inv_q}); end
      ST_IDX0: begin ma_d = $signed(33'(sx)); mb_d = $signed(33'(sy)); end
      ST_IDX1: begin ma_d = $signed(33'(cy_q)); mb_d = $signed(33'(sx)); end
      ST_IDX2: begin ma_d = $signed(33'(cz_q)); mb_d = $signed(33'(sxy_q)); end
      ST_XM: begin
        ma_d = $signed({rd_s[31], rd_s}) - $signed({lerp_a_q[31], lerp_a_q});
        mb_d = $signed(33'(fx_q));
      end
      ST_LM: begin
        ma_d = $signed({lb[31], lb}) - $signed({la[31], la});
        mb_d = $signed(33'(lf));
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = corner_addr;
    mem_wdata = item_q.write_value;
    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = clr_val_q;
      end
      ST_RW: begin
        mem_we   = (item_q.op == OP_WRITE);
        mem_addr = base_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_cnt_q <= '0;
      clr_val_q <= '0;
      clr_rsp_q <= 1'b0;
      ax_q      <= '0;
      pair_q    <= '0;
      lstep_q   <= '0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
    end else begin
      prod_q <= ma_d * mb_d;
      done_q <= 1'b0;
      case (state_q)
        ST_CLR: begin
          clr_cnt_q <= clr_cnt_q + ADW'(1);
          if (clr_cnt_q == ADW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
            if (clr_rsp_q) begin
              done_q <= 1'b1;
              rsp_q  <= '{ok: 1'b1, read_value: '0};
            end
          end
        end
        ST_IDLE: begin
          if (start) begin
            item_q <= req_i;
            cx_q   <= req_i.voxel_x[AW-1:0];
            cy_q   <= req_i.voxel_y[AW-1:0];
            cz_q   <= req_i.voxel_z[AW-1:0];
            ax_q   <= '0;
            case (req_i.op)
              OP_CLEAR: begin
                clr_cnt_q <= '0;
                clr_val_q <= req_i.write_value;
                clr_rsp_q <= 1'b1;
                state_q   <= ST_CLR;
              end
              OP_SAMPLE: begin
                if (inv_q == '0) begin
                  done_q <= 1'b1;
                  rsp_q  <= '0;
                end else begin
                  state_q <= ST_MAP;
                end
              end
              default: begin
                if (in_axis(req_i.voxel_x, sx) && in_axis(req_i.voxel_y, sy) &&
                    in_axis(req_i.voxel_z, sz)) begin
                  state_q <= ST_IDX0;
                end else begin
                  done_q <= 1'b1;
                  rsp_q  <= '0;
                end
              end
            endcase
          end
        end
        ST_MAP: begin
          if (delta[32]) begin
            done_q  <= 1'b1;
            rsp_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_MAPCHK;
          end
        end
        ST_MAPCHK: begin
          if (ip_out) begin
            done_q  <= 1'b1;
            rsp_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            case (ax_q)
              2'd0: begin
                cx_q <= ip_last ? AW'(size_sel - SW'(2)) : ip[AW-1:0];
                fx_q <= ip_last ? '0 : fr;
              end
              2'd1: begin
                cy_q <= ip_last ? AW'(size_sel - SW'(2)) : ip[AW-1:0];
                fy_q <= ip_last ? '0 : fr;
              end
              default: begin
                cz_q <= ip_last ? AW'(size_sel - SW'(2)) : ip[AW-1:0];
                fz_q <= ip_last ? '0 : fr;
              end
            endcase
            ax_q    <= ax_q + 2'd1;
            state_q <= (ax_q == 2'd2) ? ST_IDX0 : ST_MAP;
          end
        end
        ST_IDX0: state_q <= ST_IDX1;
        ST_IDX1: begin
          sxy_q   <= prod_q[SXW-1:0];
          state_q <= ST_IDX2;
        end
        ST_IDX2: begin
          base_q  <= ADW'(cx_q) + prod_q[ADW-1:0];
          state_q <= ST_IDX3;
        end
        ST_IDX3: begin
          base_q  <= base_q + prod_q[ADW-1:0];
          pair_q  <= '0;
          lstep_q <= '0;
          state_q <= (item_q.op == OP_SAMPLE) ? ST_XA : ST_RW;
        end
        ST_RW: begin
          if (item_q.op == OP_WRITE) begin
            done_q  <= 1'b1;
            rsp_q   <= '{ok: 1'b1, read_value: '0};
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_RDWAIT;
          end
        end
        ST_RDWAIT: begin
          done_q  <= 1'b1;
          rsp_q   <= '{ok: 1'b1, read_value: rd_s};
          state_q <= ST_IDLE;
        end
        ST_XA: state_q <= ST_XB;
        ST_XB: begin
          lerp_a_q <= rd_s;
          state_q  <= ST_XM;
        end
        ST_XM: state_q <= ST_XR;
        ST_XR: begin
          // shift in: oldest x-lerp ends at the top
          c_q[3]  <= c_q[2];
          c_q[2]  <= c_q[1];
          c_q[1]  <= c_q[0];
          c_q[0]  <= lerp_res;
          pair_q  <= pair_q + 2'd1;
          state_q <= (pair_q == 2'd3) ? ST_LM : ST_XA;
        end
        ST_LM: begin
          lerp_a_q <= la;
          state_q  <= ST_LR;
        end
        ST_LR: begin
          lstep_q <= lstep_q + 2'd1;
          case (lstep_q)
            2'd0: begin y0_q <= lerp_res; state_q <= ST_LM; end
            2'd1: begin y1_q <= lerp_res; state_q <= ST_LM; end
            default: begin
              done_q  <= 1'b1;
              rsp_q   <= '{ok: 1'b1, read_value: lerp_res};
              state_q <= ST_IDLE;
            end
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_sample_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.op == OP_SAMPLE && inv_q != '0) |=> busy)
    else $error("accepted sample did not hold the block busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe raised while the block was busy");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.ok) |-> (rsp_o.read_value == '0))
    else $error("failed transaction returned a non-zero value");
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLR || (state_q == ST_RW && item_q.op == OP_WRITE)))
    else $error("store written outside clear or write");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for voxel_volume_trilinear_sampler_core: directed and
// random transactions checked against an in-bench predictor.
// Depends on vvts_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import vvts_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int DEPTH     = DIM_MAX_DEF * DIM_MAX_DEF * DIM_MAX_DEF;
  localparam int QUIET_MAX = 1500000;
  localparam int SETTLE    = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  voxel_volume_trilinear_sampler_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: sparse store over a fill value, plus register copies
  logic [31:0] vox_mem [int];
  logic [31:0] fill_val = '0;
  logic [6:0]  reg_size [3] = '{SIZE_RST, SIZE_RST, SIZE_RST};
  logic [31:0] reg_origin [3] = '{32'd0, 32'd0, 32'd0};
  logic [31:0] reg_inv = INV_SCALE_RST;

  rsp_t expected_rsp [$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  bit   gaps_on = 1'b1;

  function automatic int unsigned eff_size(logic [6:0] raw);
    if (raw < SIZE_MIN) return SIZE_MIN;
    if (raw > DIM_MAX_DEF) return DIM_MAX_DEF;
    return 32'(raw);
  endfunction

  function automatic longint voxel_at(int unsigned idx);
    int unsigned k;
    k = idx % DEPTH;
    if (vox_mem.exists(k)) return longint'($signed(vox_mem[k]));
    return longint'($signed(fill_val));
  endfunction

  function automatic longint lerp(longint a, longint b, longint f);
    longint p;
    p = (b - a) * f;
    return a + (p >>> FRAC);
  endfunction

  function automatic bit map_axis(logic [31:0] pt, logic [31:0] org, int unsigned sz,
                                  output int unsigned i0, output longint fr);
    longint d;
    longint unsigned c;
    longint unsigned ip;
    i0 = 0;
    fr = 0;
    d = longint'($signed(pt)) - longint'($signed(org));
    if (d < 0) return 1'b0;
    c = (longint'(d) * longint'({32'd0, reg_inv})) >> FRAC;
    ip = c >> FRAC;
    if (ip >= sz) return 1'b0;
    i0 = int'(ip);
    fr = longint'(c & ((64'd1 << FRAC) - 1));
    if (i0 == sz - 1) begin
      i0 = sz - 2;
      fr = 0;
    end
    return 1'b1;
  endfunction

  // Work out the response of one transaction and update the store copy
  function automatic rsp_t volume_step(req_t r);
    rsp_t o;
    int unsigned sx, sy, sz, idx, i0, j0, k0, a, b;
    longint fx, fy, fz, x, y, z, c00, c10, c01, c11, c0, c1;
    o = '0;
    sx = eff_size(reg_size[0]);
    sy = eff_size(reg_size[1]);
    sz = eff_size(reg_size[2]);
    case (r.op)
      OP_READ, OP_WRITE: begin
        x = r.voxel_x;
        y = r.voxel_y;
        z = r.voxel_z;
        if (x >= 0 && x < sx && y >= 0 && y < sy && z >= 0 && z < sz) begin
          idx = (int'(x) + int'(y) * sx + int'(z) * sx * sy) % DEPTH;
          o.ok = 1'b1;
          if (r.op == OP_READ) o.read_value = 32'(voxel_at(idx));
          else vox_mem[idx] = r.write_value;
        end
      end
      OP_CLEAR: begin
        vox_mem.delete();
        fill_val = r.write_value;
        o.ok = 1'b1;
      end
      default: begin
        if (reg_inv != 0 && map_axis(r.point_x, reg_origin[0], sx, i0, fx) &&
            map_axis(r.point_y, reg_origin[1], sy, j0, fy) &&
            map_axis(r.point_z, reg_origin[2], sz, k0, fz)) begin
          a = j0 * sx + k0 * sx * sy;
          b = (j0 + 1) * sx + k0 * sx * sy;
          c00 = lerp(voxel_at(i0 + a), voxel_at(i0 + 1 + a), fx);
          c10 = lerp(voxel_at(i0 + b), voxel_at(i0 + 1 + b), fx);
          a = a + sx * sy;
          b = b + sx * sy;
          c01 = lerp(voxel_at(i0 + a), voxel_at(i0 + 1 + a), fx);
          c11 = lerp(voxel_at(i0 + b), voxel_at(i0 + 1 + b), fx);
          c0 = lerp(c00, c10, fy);
          c1 = lerp(c01, c11, fy);
          o.read_value = 32'(lerp(c0, c1, fz));
          o.ok = 1'b1;
        end
      end
    endcase
    return o;
  endfunction

  // Send one transaction after an optional gap; start stays high for a following one
  task automatic send_req(req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_i <= r;
    start <= 1'b1;
    do @(negedge clk_i); while (busy);
    expected_rsp.push_back(volume_step(r));
    @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Hold cfg_we_i high across a series; set_volume drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_SIZE_X:   reg_size[0] = val[6:0];
      CFG_SIZE_Y:   reg_size[1] = val[6:0];
      CFG_SIZE_Z:   reg_size[2] = val[6:0];
      CFG_ORIGIN_X: reg_origin[0] = val;
      CFG_ORIGIN_Y: reg_origin[1] = val;
      CFG_ORIGIN_Z: reg_origin[2] = val;
      default:      reg_inv = val;
    endcase
  endtask

  task automatic set_volume(logic [6:0] sx, logic [6:0] sy, logic [6:0] sz,
                            logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] inv);
    write_reg(CFG_SIZE_X, {25'd0, sx});
    write_reg(CFG_SIZE_Y, {25'd0, sy});
    write_reg(CFG_SIZE_Z, {25'd0, sz});
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_INV_SCALE, inv);
    cfg_we_i <= 1'b0;
  endtask

  function automatic req_t mk_access(logic [1:0] op, int x, int y, int z, logic [31:0] v);
    req_t r;
    r = '0;
    r.op = op;
    r.voxel_x = 16'(x);
    r.voxel_y = 16'(y);
    r.voxel_z = 16'(z);
    r.write_value = v;
    return r;
  endfunction

  function automatic req_t mk_sample(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    req_t r;
    r = '0;
    r.op = OP_SAMPLE;
    r.point_x = px;
    r.point_y = py;
    r.point_z = pz;
    return r;
  endfunction

  // Point whose mapped coordinate lands inside the axis, or just on its edge
  function automatic logic [31:0] point_in(int ax);
    int unsigned sz;
    longint unsigned c;
    longint d;
    sz = eff_size(reg_size[ax]);
    case ($urandom_range(0, 7))
      0:       c = longint'(sz - 1) << FRAC;
      1:       c = longint'(sz) << FRAC;
      default: c = $urandom_range(0, (sz << FRAC) - 1);
    endcase
    if (reg_inv == 0) d = c;
    else d = longint'((c << FRAC) / reg_inv);
    if ($urandom_range(0, 3) == 0) d = d + $urandom_range(0, 3);
    return 32'(longint'($signed(reg_origin[ax])) + d);
  endfunction

  function automatic int coord_in(int ax);
    case ($urandom_range(0, 15))
      0:       return $signed(16'($urandom()));
      1:       return -1;
      2:       return eff_size(reg_size[ax]);
      default: return $urandom_range(0, eff_size(reg_size[ax]) - 1);
    endcase
  endfunction

  task automatic test_voxel_access();
    send_req(mk_access(OP_WRITE, 0, 0, 0, 32'h7FFF_FFFF));
    send_req(mk_access(OP_WRITE, 63, 63, 63, 32'h8000_0000));
    send_req(mk_access(OP_WRITE, 1, 0, 0, 32'h0001_0000));
    send_req(mk_access(OP_READ, 0, 0, 0, '0));
    send_req(mk_access(OP_READ, 63, 63, 63, '0));
    send_req(mk_access(OP_READ, 64, 0, 0, '0));
    send_req(mk_access(OP_WRITE, -1, 0, 0, 32'hDEAD_BEEF));
    send_req(mk_access(OP_READ, -32768, 32767, -32768, '0));
    send_req(mk_access(OP_READ, 32767, -32768, 32767, '0));
    send_req(mk_access(OP_READ, 0, 0, 64, '0));
  endtask

  task automatic test_sampling();
    send_req(mk_sample(32'h0000_8000, 32'h0, 32'h0));
    send_req(mk_sample(32'h003F_8000, 32'h003F_0000, 32'h003F_FFFF));
    send_req(mk_sample(32'h0040_0000, 32'h0, 32'h0));
    send_req(mk_sample(32'hFFFF_FFFF, 32'h0, 32'h0));
    send_req(mk_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    send_req(mk_sample(32'h0000_C000, 32'h0000_4000, 32'h0000_2000));
    drain();
    set_volume(7'd0, 7'd1, 7'd127, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_req(mk_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    send_req(mk_access(OP_READ, 1, 1, 63, '0));
    drain();
    set_volume(7'd2, 7'd2, 7'd65, 32'h8000_0000, 32'h0, 32'hFFFF_0000, 32'hFFFF_FFFF);
    send_req(mk_sample(32'h8000_0000, 32'h0000_0001, 32'hFFFF_0000));
    send_req(mk_sample(32'h8000_8000, 32'h0, 32'hFFFF_0000));
    drain();
  endtask

  task automatic test_clear();
    set_volume(7'd64, 7'd64, 7'd64, 32'h0, 32'h0, 32'h0, INV_SCALE_RST);
    send_req(mk_access(OP_CLEAR, 0, 0, 0, 32'hA5A5_5A5A));
    send_req(mk_access(OP_READ, 63, 0, 63, '0));
    send_req(mk_sample(32'h0000_8000, 32'h0001_8000, 32'h0));
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    req_t r;
    logic [31:0] inv;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 7))
        0:       inv = 32'h0;
        1:       inv = 32'hFFFF_FFFF;
        2:       inv = $urandom();
        3:       inv = 32'h0000_8000;
        4:       inv = 32'h0002_0000;
        default: inv = INV_SCALE_RST;
      endcase
      if (p % 4 == 3)
        set_volume(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)), $urandom(), $urandom(), $urandom(), inv);
      else
        set_volume(7'($urandom_range(2, 6)), 7'($urandom_range(2, 6)),
                   7'($urandom_range(2, 6)), $urandom(), $urandom(), $urandom(), inv);
      gaps_on = (p % 3 != 1);
      for (int n = 0; n < per_phase; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: r = mk_access(OP_WRITE, coord_in(0), coord_in(1), coord_in(2), $urandom());
          3, 4:    r = mk_access(OP_READ, coord_in(0), coord_in(1), coord_in(2), $urandom());
          5:       r = mk_sample($urandom(), $urandom(), $urandom());
          default: r = mk_sample(point_in(0), point_in(1), point_in(2));
        endcase
        // keep stray bits of unused fields moving too
        if ($urandom_range(0, 1)) begin
          r.voxel_x = r.op == OP_SAMPLE ? 16'($urandom()) : r.voxel_x;
          r.point_x = r.op == OP_SAMPLE ? r.point_x : $urandom();
        end
        send_req(r);
      end
      if (p == phases / 2) send_req(mk_access(OP_CLEAR, 0, 0, 0, $urandom()));
      drain();
    end
    gaps_on = 1'b1;
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result ok=%0d value=%h",
                                       rsp_o.ok, rsp_o.read_value);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_o.ok !== want.ok || rsp_o.read_value !== want.read_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ok=%0d value=%h, got ok=%0d value=%h",
                     want.ok, want.read_value, rsp_o.ok, rsp_o.read_value);
        end
      end
    end
  end

  // Watchdog: end the run after too long without a transaction either way
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_voxel_access();
    test_sampling();
    test_clear();
    test_random(12, 140);
    drain();
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
src/vvts_pkg.sv
src/vvts_store.sv
src/voxel_volume_trilinear_sampler_core.sv
verif/tb_top.sv
